@@ rtl/core/double_to_custom_float_defines.svh @@
// Assertion macros for the binary64 to minifloat converter checker.
// Included by the checker file only.
`ifndef DOUBLE_TO_CUSTOM_FLOAT_DEFINES_SVH
`define DOUBLE_TO_CUSTOM_FLOAT_DEFINES_SVH
`define D2CF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define D2CF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/core/d2cf_pkg.sv @@
// Shared types and constants for the binary64 to minifloat converter.
// No dependencies.
package d2cf_pkg;
  localparam int unsigned ExpLo  = 2;
  localparam int unsigned ExpHi  = 11;
  localparam int unsigned FracLo = 1;
  localparam int unsigned FracHi = 52;
  localparam logic [3:0] ExpReset  = 4'd8;
  localparam logic [5:0] FracReset = 6'd23;
  localparam logic [10:0] XExpAllOnes = 11'h7ff;
  localparam logic [10:0] Bias64      = 11'd1023;

  typedef enum logic [1:0] {
    KindNormal = 2'd0,
    KindZero   = 2'd1,
    KindSpec   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [3:0] ew;
    logic [5:0] fw;
  } fmt_t;
endpackage

@@ rtl/core/d2cf_cfg.sv @@
// Configuration registers and effective width computation.
// Depends on d2cf_pkg.
module d2cf_cfg #(
  parameter int unsigned MAX_TOTAL_WIDTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output d2cf_pkg::fmt_t  fmt_o
);
  import d2cf_pkg::*;

  localparam int unsigned EMaxW = MAX_TOTAL_WIDTH - 2;

  logic [3:0] exp_q;
  logic [5:0] frac_q;
  logic       wr;
  logic [6:0] e_eff;
  logic [6:0] f_eff;

  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= ExpReset;
      frac_q <= FracReset;
    end else if (wr) begin
      unique case (paddr)
        3'd0:    exp_q  <= pwdata[3:0];
        3'd4:    frac_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      3'd0:    prdata = {28'd0, exp_q};
      3'd4:    prdata = {26'd0, frac_q};
      default: prdata = '0;
    endcase
  end

  always_comb begin
    e_eff = {3'd0, exp_q};
    if (e_eff < 7'(ExpLo)) e_eff = 7'(ExpLo);
    if (e_eff > 7'(ExpHi)) e_eff = 7'(ExpHi);
    if (e_eff > 7'(EMaxW)) e_eff = 7'(EMaxW);
    f_eff = {1'b0, frac_q};
    if (f_eff < 7'(FracLo)) f_eff = 7'(FracLo);
    if (f_eff > 7'(FracHi)) f_eff = 7'(FracHi);
    if (7'd1 + e_eff + f_eff > 7'(MAX_TOTAL_WIDTH)) f_eff = 7'(MAX_TOTAL_WIDTH - 1) - e_eff;
    fmt_o.ew = e_eff[3:0];
    fmt_o.fw = f_eff[5:0];
  end
endmodule

@@ rtl/core/d2cf_round.sv @@
// Stage 1 and 2: unpack, fraction alignment and rounding.
// Depends on d2cf_pkg.
module d2cf_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [63:0]       value_bits_i,
  input  d2cf_pkg::fmt_t    fmt_i,
  output logic              valid_o,
  output logic              sign_o,
  output d2cf_pkg::kind_e   kind_o,
  output logic              nan_o,
  output logic              inexact_o,
  output logic signed [12:0] biased_o,
  output logic [52:0]       keep_o,
  output d2cf_pkg::fmt_t    fmt_o
);
  import d2cf_pkg::*;

  logic        v1_q, v2_q;
  logic        s1_q, s2_q;
  kind_e       k1_q, k2_q;
  logic        n1_q, n2_q;
  logic [51:0] keep1_q;
  logic        rnd1_q, inx1_q;
  logic signed [12:0] b1_q, b2_q;
  fmt_t        f1_q, f2_q;
  logic        x2_q;
  logic [52:0] keep2_q;

  logic [10:0] xexp;
  logic [51:0] xfrac;
  logic [5:0]  shift;
  logic [51:0] keep_d;
  logic [51:0] rem;
  logic [51:0] half;
  logic [51:0] rmask;
  logic        lsb;
  logic [52:0] sum;
  logic [52:0] fmask;
  logic signed [12:0] b_d;
  kind_e       k_d;

  assign xexp  = value_bits_i[62:52];
  assign xfrac = value_bits_i[51:0];
  assign shift = 6'd52 - fmt_i.fw;
  assign keep_d = xfrac >> shift;
  assign rmask = (52'd1 << shift) - 52'd1;
  assign rem   = xfrac & rmask;
  assign half  = (shift == 6'd0) ? 52'd0 : (52'd1 << (shift - 6'd1));
  assign lsb   = keep_d[0];
  assign b_d   = $signed({2'b00, xexp}) - $signed({2'b00, Bias64})
               + $signed(13'((13'd1 << (fmt_i.ew - 4'd1)) - 13'd1));

  always_comb begin
    if (xexp == XExpAllOnes) k_d = KindSpec;
    else if (xexp == 11'd0)  k_d = KindZero;
    else                     k_d = KindNormal;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q    <= value_bits_i[63];
      k1_q    <= k_d;
      n1_q    <= (xfrac != 52'd0);
      keep1_q <= (k_d == KindSpec) ? ((xfrac >> shift) | (52'd1 << (fmt_i.fw - 6'd1)))
                                   : keep_d;
      inx1_q  <= (rem != 52'd0);
      rnd1_q  <= (rem != 52'd0) && ((rem > half) || ((rem == half) && lsb));
      b1_q    <= b_d;
      f1_q    <= fmt_i;
    end
  end

  assign sum   = {1'b0, keep1_q} + {52'd0, rnd1_q};
  assign fmask = (53'd1 << f1_q.fw) - 53'd1;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_q <= s1_q;
      k2_q <= k1_q;
      n2_q <= n1_q;
      x2_q <= inx1_q;
      f2_q <= f1_q;
      if (k1_q == KindNormal && sum > fmask) begin
        keep2_q <= '0;
        b2_q    <= b1_q + 13'sd1;
      end else begin
        keep2_q <= (k1_q == KindNormal) ? sum : {1'b0, keep1_q};
        b2_q    <= b1_q;
      end
    end
  end

  assign valid_o   = v2_q;
  assign sign_o    = s2_q;
  assign kind_o    = k2_q;
  assign nan_o     = n2_q;
  assign inexact_o = x2_q;
  assign biased_o  = b2_q;
  assign keep_o    = keep2_q;
  assign fmt_o     = f2_q;
endmodule

@@ rtl/core/d2cf_pack.sv @@
// Stage 3: range check and packing into the target format.
// Depends on d2cf_pkg.
module d2cf_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic              sign_i,
  input  d2cf_pkg::kind_e   kind_i,
  input  logic              nan_i,
  input  logic              inexact_i,
  input  logic signed [12:0] biased_i,
  input  logic [52:0]       keep_i,
  input  d2cf_pkg::fmt_t    fmt_i,
  output logic              valid_o,
  output logic [63:0]       packed_value_o,
  output logic              overflowed_o,
  output logic              underflowed_o,
  output logic              inexact_o
);
  import d2cf_pkg::*;

  logic        v_q;
  logic [63:0] p_q;
  logic        o_q, u_q, x_q;
  logic [63:0] sgn;
  logic [63:0] emax_sh;
  logic [12:0] emax;
  logic [63:0] p_d;
  logic        o_d, u_d, x_d;

  assign sgn     = {63'd0, sign_i} << (7'(fmt_i.ew) + 7'(fmt_i.fw));
  assign emax    = (13'd1 << fmt_i.ew) - 13'd1;
  assign emax_sh = {51'd0, emax} << fmt_i.fw;

  always_comb begin
    p_d = sgn;
    o_d = 1'b0;
    u_d = 1'b0;
    x_d = 1'b0;
    case (kind_i)
      KindSpec: p_d = sgn | emax_sh | (nan_i ? {11'd0, keep_i} : 64'd0);
      KindZero: begin
        u_d = nan_i;
        x_d = nan_i;
      end
      default: begin
        x_d = inexact_i;
        if (biased_i >= $signed(emax)) begin
          p_d = sgn | emax_sh;
          o_d = 1'b1;
          x_d = 1'b1;
        end else if (biased_i <= 13'sd0) begin
          u_d = 1'b1;
          x_d = 1'b1;
        end else begin
          p_d = sgn | ({51'd0, biased_i} << fmt_i.fw) | {11'd0, keep_i};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (adv_i) v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q <= p_d;
      o_q <= o_d;
      u_q <= u_d;
      x_q <= x_d;
    end
  end

  assign valid_o        = v_q;
  assign packed_value_o = p_q;
  assign overflowed_o   = o_q;
  assign underflowed_o  = u_q;
  assign inexact_o      = x_q;
endmodule

@@ rtl/core/double_to_custom_float.sv @@
// Binary64 to configurable minifloat converter, top level.
// Input word: value_bits_i with valid_i; stall_o pushes back the sender.
// Output word: packed_value_o and flags with valid_o; stall_i from receiver.
// Throughput: one word per cycle while no stall holds the pipeline.
// The three register stages are unpack/align, round, and range check/pack.
// The whole pipeline advances when the output slot is empty or taken, so
// stall_o follows stall_i while the output holds a word.
// Reset empties every stage and loads exponent width 8, fraction width 23.
// A stall holds all stages; nothing is lost or repeated.
// Width registers sit on the APB port: exponent width at 0x0, fraction at 0x4.
// Write them only while the pipeline is empty.
// Depends on d2cf_pkg, d2cf_cfg, d2cf_round and d2cf_pack.
module double_to_custom_float #(
  parameter int unsigned MAX_TOTAL_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] value_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] packed_value_o,
  output logic        overflowed_o,
  output logic        underflowed_o,
  output logic        inexact_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import d2cf_pkg::*;

  fmt_t  fmt, fmt2;
  logic  adv;
  logic  v2, s2, n2, x2;
  kind_e k2;
  logic signed [12:0] b2;
  logic [52:0] keep2;

  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;
  assign pready  = 1'b1;

  d2cf_cfg #(.MAX_TOTAL_WIDTH(MAX_TOTAL_WIDTH)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .fmt_o(fmt)
  );

  d2cf_round u_round (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i, .value_bits_i, .fmt_i(fmt),
    .valid_o(v2), .sign_o(s2), .kind_o(k2), .nan_o(n2), .inexact_o(x2),
    .biased_o(b2), .keep_o(keep2), .fmt_o(fmt2)
  );

  d2cf_pack u_pack (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v2), .sign_i(s2), .kind_i(k2),
    .nan_i(n2), .inexact_i(x2), .biased_i(b2), .keep_i(keep2), .fmt_i(fmt2),
    .valid_o, .packed_value_o, .overflowed_o, .underflowed_o, .inexact_o
  );
endmodule

@@ rtl/core/d2cf_checker.sv @@
// Port-level checker for the converter, bound to the top level.
// Depends on double_to_custom_float_defines.svh.
`include "double_to_custom_float_defines.svh"
module d2cf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        stall_i,
  input logic        stall_o,
  input logic [63:0] packed_value_o,
  input logic        overflowed_o,
  input logic        underflowed_o,
  input logic        pready
);
  `D2CF_ASSERT(a_hold, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(packed_value_o), "output word changed under stall")
  `D2CF_ASSERT(a_flags, clk_i, rst_ni, valid_o |-> !(overflowed_o && underflowed_o), "both overflow and underflow")
  `D2CF_ASSERT(a_stall, clk_i, rst_ni, stall_o |-> valid_o && stall_i, "stall without a blocked output")
  `D2CF_ASSERT_ALWAYS(a_ready, clk_i, pready, "pready low")
endmodule

bind double_to_custom_float d2cf_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .stall_i, .stall_o, .packed_value_o,
  .overflowed_o, .underflowed_o, .pready
);
